// ===== rtl/palette_expand_opaque_span_extract_top_defines.svh =====
// Assertion shorthands shared by the RTL.
`ifndef PALETTE_EXPAND_OPAQUE_SPAN_EXTRACT_TOP_DEFINES_SVH
`define PALETTE_EXPAND_OPAQUE_SPAN_EXTRACT_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PESX_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PESX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pesx_pkg.sv =====
package pesx_pkg;

    localparam int DEF_MAX_WIDTH     = 4096;
    localparam int DEF_MAX_HEIGHT    = 4096;
    localparam int DEF_PALETTE_DEPTH = 256;
    localparam int DEF_QUEUE_DEPTH   = 4;

    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_PIXEL   = 1'b1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_SPAN  = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic        is_pixel;
        logic [7:0]  addr;
        logic [23:0] rgb;
        logic [23:0] pix_num;
        logic        has_span;
        logic [11:0] span_row;
        logic [11:0] span_start;
        logic [12:0] span_len;
        logic [10:0] zone;
    } pesx_item_t;

endpackage

// ===== rtl/pesx_front.sv =====
`include "palette_expand_opaque_span_extract_top_defines.svh"

module pesx_front #(
    parameter int MAX_WIDTH  = pesx_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pesx_pkg::DEF_MAX_HEIGHT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [12:0]           cfg_data,
    input  logic                  in_fire,
    input  logic                  cmd,
    input  logic [7:0]            entry_index,
    input  logic [7:0]            entry_red,
    input  logic [7:0]            entry_green,
    input  logic [7:0]            entry_blue,
    input  logic [7:0]            data_byte,
    output logic                  push,
    output pesx_pkg::pesx_item_t  push_item
);

    logic [12:0] width_reg, width_next;
    logic [12:0] height_reg, height_next;
    logic [12:0] col_reg, col_next;
    logic [12:0] row_reg, row_next;
    logic [1:0]  pad_reg, pad_next;
    logic        in_span_reg, in_span_next;
    logic [12:0] span_begin_reg, span_begin_next;
    logic [10:0] zones_reg, zones_next;
    logic [23:0] lin_reg, lin_next;
    logic        done_reg, done_next;

    logic [12:0] w_eff, h_eff;
    logic        is_pix, pix_take, row_end, row_last, nz, has_span;
    logic [12:0] s_start, s_len;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = 13'd1;
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = 13'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = 13'd1;
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = 13'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign is_pix   = (cmd == pesx_pkg::CMD_PIXEL);
    assign pix_take = in_fire && is_pix && !done_reg && (pad_reg == 2'd0);
    assign row_end  = ({1'b0, col_reg} + 14'd1) >= {1'b0, w_eff};
    assign row_last = ({1'b0, row_reg} + 14'd1) >= {1'b0, h_eff};
    assign nz       = (data_byte != 8'd0);

    always_comb
    begin
        has_span = 1'b0;
        s_start  = span_begin_reg;
        s_len    = col_reg - span_begin_reg;
        if (in_span_reg)
        begin
            if (!nz)
                has_span = 1'b1;
            else if (row_end)
            begin
                has_span = 1'b1;
                s_len    = col_reg - span_begin_reg + 13'd1;
            end
        end
        else if (nz && row_end)
        begin
            has_span = 1'b1;
            s_start  = col_reg;
            s_len    = 13'd1;
        end
    end

    always_comb
    begin
        width_next      = width_reg;
        height_next     = height_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        pad_next        = pad_reg;
        in_span_next    = in_span_reg;
        span_begin_next = span_begin_reg;
        zones_next      = zones_reg;
        lin_next        = lin_reg;
        done_next       = done_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                pesx_pkg::REG_WIDTH:  width_next  = cfg_data;
                pesx_pkg::REG_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end

        if (in_fire && is_pix && !done_reg && (pad_reg != 2'd0))
            pad_next = pad_reg - 2'd1;

        if (pix_take)
        begin
            lin_next     = lin_reg + 24'd1;
            in_span_next = nz && !row_end;
            if (!in_span_reg && nz)
                span_begin_next = col_reg;
            if (has_span)
                zones_next = zones_reg + 11'd1;
            if (row_end)
            begin
                col_next   = '0;
                zones_next = '0;
                if (row_last)
                begin
                    done_next = 1'b1;
                    pad_next  = 2'd0;
                end
                else
                begin
                    row_next = row_reg + 13'd1;
                    pad_next = 2'd0 - w_eff[1:0];
                end
            end
            else
                col_next = col_reg + 13'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= 13'd1;
            height_reg     <= 13'd1;
            col_reg        <= '0;
            row_reg        <= '0;
            pad_reg        <= '0;
            in_span_reg    <= 1'b0;
            span_begin_reg <= '0;
            zones_reg      <= '0;
            lin_reg        <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            width_reg      <= width_next;
            height_reg     <= height_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            pad_reg        <= pad_next;
            in_span_reg    <= in_span_next;
            span_begin_reg <= span_begin_next;
            zones_reg      <= zones_next;
            lin_reg        <= lin_next;
            done_reg       <= done_next;
        end
    end

    assign push = in_fire && (!is_pix || pix_take);

    always_comb
    begin
        push_item.is_pixel   = is_pix;
        push_item.addr       = is_pix ? data_byte : entry_index;
        push_item.rgb        = {entry_red, entry_green, entry_blue};
        push_item.pix_num    = lin_reg;
        push_item.has_span   = has_span;
        push_item.span_row   = row_reg[11:0];
        push_item.span_start = s_start[11:0];
        push_item.span_len   = s_len;
        push_item.zone       = zones_reg;
    end

    `PESX_ASSERT_IMPL(a_span_not_after_done, in_span_reg, !done_reg, "open span after image end")
    `PESX_ASSERT_IMPL(a_span_begin_le_col, in_span_reg, span_begin_reg <= col_reg, "bad span start")

endmodule

// ===== rtl/pesx_queue.sv =====
module pesx_queue #(
    parameter int DEPTH = pesx_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pesx_pkg::pesx_item_t  push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  nonempty,
    output pesx_pkg::pesx_item_t  head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pesx_pkg::pesx_item_t slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== rtl/pesx_back.sv =====
`include "palette_expand_opaque_span_extract_top_defines.svh"

module pesx_back #(
    parameter int PALETTE_DEPTH = pesx_pkg::DEF_PALETTE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_nonempty,
    input  pesx_pkg::pesx_item_t  head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  kind,
    output logic [23:0]           pixel_number,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue,
    output logic [11:0]           span_row,
    output logic [11:0]           span_start_col,
    output logic [12:0]           span_length,
    output logic [10:0]           zone_ordinal,
    output logic                  last
);

    localparam int PAW = $clog2(PALETTE_DEPTH);

    logic [23:0] pal_mem [PALETTE_DEPTH];

    logic                 a_valid_reg, a_valid_next;
    logic                 a_phase_reg, a_phase_next;
    pesx_pkg::pesx_item_t a_item_reg;
    logic [23:0]          rd_rgb_reg;
    logic                 a_oor_reg;

    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [23:0] out_pix_reg, out_pix_next;
    logic [23:0] out_rgb_reg, out_rgb_next;
    logic [11:0] out_row_reg, out_row_next;
    logic [11:0] out_start_reg, out_start_next;
    logic [12:0] out_len_reg, out_len_next;
    logic [10:0] out_zone_reg, out_zone_next;
    logic        out_last_reg, out_last_next;

    logic out_free, a_done, a_free, pop_pix, pop_wr, addr_ok;
    logic out_span, out_pix_open;

    assign out_free = !out_valid_reg || !out_stall;
    assign a_done   = a_valid_reg && out_free && (a_phase_reg || !a_item_reg.has_span);
    assign a_free   = !a_valid_reg || a_done;
    assign pop      = q_nonempty && (!head.is_pixel || a_free);
    assign pop_pix  = pop && head.is_pixel;
    assign pop_wr   = pop && !head.is_pixel;
    assign addr_ok  = (32'(head.addr) < PALETTE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (pop_wr && addr_ok)
            pal_mem[head.addr[PAW-1:0]] <= head.rgb;
        if (pop_pix)
        begin
            rd_rgb_reg <= pal_mem[head.addr[PAW-1:0]];
            a_oor_reg  <= !addr_ok;
            a_item_reg <= head;
        end
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        a_phase_next = a_phase_reg;
        if (pop_pix)
        begin
            a_valid_next = 1'b1;
            a_phase_next = 1'b0;
        end
        else if (a_done)
            a_valid_next = 1'b0;
        else if (a_valid_reg && out_free && !a_phase_reg)
            a_phase_next = 1'b1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_pix_next   = out_pix_reg;
        out_rgb_next   = out_rgb_reg;
        out_row_next   = out_row_reg;
        out_start_next = out_start_reg;
        out_len_next   = out_len_reg;
        out_zone_next  = out_zone_reg;
        out_last_next  = out_last_reg;
        if (out_free)
        begin
            out_valid_next = a_valid_reg;
            if (a_valid_reg && !a_phase_reg)
            begin
                out_kind_next  = pesx_pkg::KIND_PIXEL;
                out_pix_next   = a_item_reg.pix_num;
                out_rgb_next   = a_oor_reg ? 24'd0 : rd_rgb_reg;
                out_row_next   = '0;
                out_start_next = '0;
                out_len_next   = '0;
                out_zone_next  = '0;
                out_last_next  = !a_item_reg.has_span;
            end
            else if (a_valid_reg)
            begin
                out_kind_next  = pesx_pkg::KIND_SPAN;
                out_pix_next   = '0;
                out_rgb_next   = '0;
                out_row_next   = a_item_reg.span_row;
                out_start_next = a_item_reg.span_start;
                out_len_next   = a_item_reg.span_len;
                out_zone_next  = a_item_reg.zone;
                out_last_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            a_phase_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            a_phase_reg   <= a_phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg  <= out_kind_next;
        out_pix_reg   <= out_pix_next;
        out_rgb_reg   <= out_rgb_next;
        out_row_reg   <= out_row_next;
        out_start_reg <= out_start_next;
        out_len_reg   <= out_len_next;
        out_zone_reg  <= out_zone_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_kind_reg;
    assign pixel_number   = out_pix_reg;
    assign red            = out_rgb_reg[23:16];
    assign green          = out_rgb_reg[15:8];
    assign blue           = out_rgb_reg[7:0];
    assign span_row       = out_row_reg;
    assign span_start_col = out_start_reg;
    assign span_length    = out_len_reg;
    assign zone_ordinal   = out_zone_reg;
    assign last           = out_last_reg;

    assign out_span     = out_valid_reg && (out_kind_reg == pesx_pkg::KIND_SPAN);
    assign out_pix_open = out_valid_reg && !out_stall && (out_kind_reg == pesx_pkg::KIND_PIXEL)
                          && !out_last_reg;

    `PESX_ASSERT_IMPL(a_span_is_last, out_span, out_last_reg, "span record not last")
    `PESX_ASSERT_NEXT(a_span_follows, out_pix_open, out_span, "span record missing")
    `PESX_ASSERT_IMPL(a_phase_has_span, a_valid_reg && a_phase_reg, a_item_reg.has_span, "span phase without span")

endmodule

// ===== rtl/palette_expand_opaque_span_extract_top.sv =====
// Indexed bitmap decoder with opaque-span records.
// Input channel (in_valid/in_stall): cmd 0 writes palette entry entry_index with
// entry_red/green/blue; cmd 1 carries one raw byte of a bottom-up 8-bit pixel array.
// Row padding to four bytes is dropped; bytes after the last row are dropped.
// Output channel (out_valid/out_stall): per pixel one colour result (kind 0), then
// a span record (kind 1) when the pixel closes an opaque run; last marks the final
// result of a byte. Config: cfg_we/cfg_index/cfg_data sets width (0) and height (1);
// they are to be written only while the block is idle, which the block does not enforce.
// A pixel byte passes through the queue, the lookup stage and the output register.
// Throughput: one byte per cycle while in_stall is low; a byte that closes a span
// takes a pixel phase and a span phase; the span record follows the pixel result.
// Palette writes pass through the queue and give no result.
// A four-entry queue separates the byte classifier from the palette lookup stage.
// Reset clears counters and span state and sets width and height to 1; palette
// contents are undefined until written.
// With out_stall high results hold; the queue fills and in_stall rises.
module palette_expand_opaque_span_extract_top #(
    parameter int MAX_WIDTH     = pesx_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = pesx_pkg::DEF_MAX_HEIGHT,
    parameter int PALETTE_DEPTH = pesx_pkg::DEF_PALETTE_DEPTH,
    parameter int QUEUE_DEPTH   = pesx_pkg::DEF_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  entry_red,
    input  logic [7:0]  entry_green,
    input  logic [7:0]  entry_blue,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [23:0] pixel_number,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [11:0] span_row,
    output logic [11:0] span_start_col,
    output logic [12:0] span_length,
    output logic [10:0] zone_ordinal,
    output logic        last
);

    logic                 in_fire, push, full, pop, nonempty;
    pesx_pkg::pesx_item_t push_item, head;

    assign in_stall = full;
    assign in_fire  = in_valid && !in_stall;

    pesx_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_fire     (in_fire),
        .cmd         (cmd),
        .entry_index (entry_index),
        .entry_red   (entry_red),
        .entry_green (entry_green),
        .entry_blue  (entry_blue),
        .data_byte   (data_byte),
        .push        (push),
        .push_item   (push_item)
    );

    pesx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .nonempty  (nonempty),
        .head      (head)
    );

    pesx_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_nonempty     (nonempty),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .pixel_number   (pixel_number),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .span_row       (span_row),
        .span_start_col (span_start_col),
        .span_length    (span_length),
        .zone_ordinal   (zone_ordinal),
        .last           (last)
    );

endmodule
